FILE: rtl/dllm_pkg.sv
// Package with the sizes, command codes and shared types of the linked list manager.
`timescale 1ns / 1ps
`default_nettype none

package dllm_pkg;

    localparam int NODE_COUNT = 64;
    localparam int LIST_COUNT = 8;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LIST_W     = $clog2(LIST_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [LIST_W-1:0] list_id;
        logic [NODE_W-1:0] node_id;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] next_node;
        logic [NODE_W-1:0] prev_node;
        logic [LIST_W-1:0] owner;
    } node_rd_t;

    typedef struct packed {
        logic              next_we;
        logic [NODE_W-1:0] next_addr;
        logic [NODE_W-1:0] next_data;
        logic              prev_we;
        logic [NODE_W-1:0] prev_addr;
        logic [NODE_W-1:0] prev_data;
        logic              owner_we;
        logic [NODE_W-1:0] owner_addr;
        logic [LIST_W-1:0] owner_data;
    } node_wr_t;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  list_count;
        logic              owner_valid;
        logic [LIST_W-1:0] owner_list;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/dllm_ram.sv
// Generic single write, single read RAM with registered read data and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module dllm_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/dllm_exec.sv
// Command execution: node ownership bits, list records and the link pointer updates.
`timescale 1ns / 1ps
`default_nettype none

module dllm_exec
    import dllm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     go,
    input  wire req_t     req,
    input  wire node_rd_t rd,
    output node_wr_t      wr,
    output res_t          res
);

    logic [NODE_COUNT-1:0] owned_reg;
    logic [NODE_COUNT-1:0] owned_next;
    logic [NODE_W-1:0]     head_reg [LIST_COUNT];
    logic [NODE_W-1:0]     head_next [LIST_COUNT];
    logic [NODE_W-1:0]     tail_reg [LIST_COUNT];
    logic [NODE_W-1:0]     tail_next [LIST_COUNT];
    logic [CNT_W-1:0]      size_reg [LIST_COUNT];
    logic [CNT_W-1:0]      size_next [LIST_COUNT];

    logic              owned;
    logic [LIST_W-1:0] lsel;
    logic [NODE_W-1:0] hd;
    logic [NODE_W-1:0] tl;
    logic [CNT_W-1:0]  sz;
    logic              empty;
    logic              has_next;
    logic              has_prev;
    logic              do_link;
    logic              do_rem;

    // The successor of a tail and the predecessor of a head are never stored;
    // they follow from the list record, so each command writes each pointer
    // store at most once.
    always_comb
    begin
        owned    = owned_reg[req.node_id];
        lsel     = ((req.command == CMD_REMOVE) || (req.command == CMD_QUERY)) ?
                   rd.owner : req.list_id;
        hd       = head_reg[lsel];
        tl       = tail_reg[lsel];
        sz       = size_reg[lsel];
        empty    = (sz == '0);
        has_next = (req.node_id != tl);
        has_prev = (req.node_id != hd);
        do_link  = go && ((req.command == CMD_APPEND) || (req.command == CMD_PUSH)) && !owned;
        do_rem   = go && (req.command == CMD_REMOVE) && owned;

        owned_next = owned_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        size_next  = size_reg;
        wr         = '0;

        if (do_link)
        begin
            owned_next[req.node_id] = 1'b1;
            size_next[lsel]         = sz + CNT_W'(1);
            wr.owner_we             = 1'b1;
            wr.owner_addr           = req.node_id;
            wr.owner_data           = req.list_id;
            if (empty)
            begin
                head_next[lsel] = req.node_id;
                tail_next[lsel] = req.node_id;
            end
            else if (req.command == CMD_APPEND)
            begin
                tail_next[lsel] = req.node_id;
                wr.next_we      = 1'b1;
                wr.next_addr    = tl;
                wr.next_data    = req.node_id;
                wr.prev_we      = 1'b1;
                wr.prev_addr    = req.node_id;
                wr.prev_data    = tl;
            end
            else
            begin
                head_next[lsel] = req.node_id;
                wr.next_we      = 1'b1;
                wr.next_addr    = req.node_id;
                wr.next_data    = hd;
                wr.prev_we      = 1'b1;
                wr.prev_addr    = hd;
                wr.prev_data    = req.node_id;
            end
        end

        if (do_rem)
        begin
            owned_next[req.node_id] = 1'b0;
            size_next[lsel]         = sz - CNT_W'(1);
            if (!has_next)
            begin
                tail_next[lsel] = rd.prev_node;
            end
            if (!has_prev)
            begin
                head_next[lsel] = rd.next_node;
            end
            if (has_next && has_prev)
            begin
                wr.next_we   = 1'b1;
                wr.next_addr = rd.prev_node;
                wr.next_data = rd.next_node;
                wr.prev_we   = 1'b1;
                wr.prev_addr = rd.next_node;
                wr.prev_data = rd.prev_node;
            end
        end

        res = '0;
        unique case (req.command)
            CMD_APPEND, CMD_PUSH:
            begin
                res.owner_valid = 1'b1;
                if (owned)
                begin
                    res.owner_list = rd.owner;
                end
                else
                begin
                    res.accepted   = 1'b1;
                    res.list_count = sz + CNT_W'(1);
                    res.owner_list = req.list_id;
                end
            end
            CMD_REMOVE:
            begin
                if (owned)
                begin
                    res.accepted   = 1'b1;
                    res.list_count = sz - CNT_W'(1);
                end
            end
            CMD_QUERY:
            begin
                res.accepted = 1'b1;
                if (owned)
                begin
                    res.list_count  = sz;
                    res.owner_valid = 1'b1;
                    res.owner_list  = rd.owner;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_reg <= '0;
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                size_reg[i] <= '0;
            end
        end
        else
        begin
            owned_reg <= owned_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            size_reg  <= size_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/doubly_linked_list_manager.sv
// Top level of the linked list manager: request register, node RAMs and result register.
//
//  channel  | valid / ready         | payload
//  ---------+-----------------------+-------------------------------------------------
//  request  | cmd_valid / cmd_ready | command, list_id, node_id
//  result   | res_valid / res_ready | accepted, list_count, owner_valid, owner_list
//
// A request is registered while its node is read from the pointer and owner RAMs;
// once the result register is free it executes and its result is registered there.
// One request is taken every cycle while no stalled result holds the request register;
// a write by the executing request is forwarded to a read taken at the same edge.
// Reset clears all ownership bits and list records at once; no clearing pass is needed.
// While a result waits on res_ready, a request in the request register holds there and
// cmd_ready stays low, so at most two requests are in flight.
`timescale 1ns / 1ps
`default_nettype none

module doubly_linked_list_manager
    import dllm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire logic [1:0]        command,
    input  wire logic [LIST_W-1:0] list_id,
    input  wire logic [NODE_W-1:0] node_id,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic                   accepted,
    output logic [CNT_W-1:0]       list_count,
    output logic                   owner_valid,
    output logic [LIST_W-1:0]      owner_list
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    req_t     s1_req_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    res_t     out_res_reg;
    logic     go;
    logic     take;
    node_rd_t rd;
    node_wr_t wr;
    res_t     res;

    assign go        = s1_valid_reg && (!out_valid_reg || res_ready);
    assign cmd_ready = !s1_valid_reg || go;
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        s1_valid_next  = take ? 1'b1 : (go ? 1'b0 : s1_valid_reg);
        out_valid_next = go ? 1'b1 : ((out_valid_reg && res_ready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_req_reg.command <= cmd_t'(command);
            s1_req_reg.list_id <= list_id;
            s1_req_reg.node_id <= node_id;
        end
        if (go)
        begin
            out_res_reg <= res;
        end
    end

    dllm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_next_ram (
        .clk   (clk),
        .we    (wr.next_we),
        .waddr (wr.next_addr),
        .wdata (wr.next_data),
        .re    (take),
        .raddr (node_id),
        .rdata (rd.next_node)
    );

    dllm_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_prev_ram (
        .clk   (clk),
        .we    (wr.prev_we),
        .waddr (wr.prev_addr),
        .wdata (wr.prev_data),
        .re    (take),
        .raddr (node_id),
        .rdata (rd.prev_node)
    );

    dllm_ram #(
        .WIDTH (LIST_W),
        .DEPTH (NODE_COUNT)
    ) u_owner_ram (
        .clk   (clk),
        .we    (wr.owner_we),
        .waddr (wr.owner_addr),
        .wdata (wr.owner_data),
        .re    (take),
        .raddr (node_id),
        .rdata (rd.owner)
    );

    dllm_exec u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .req   (s1_req_reg),
        .rd    (rd),
        .wr    (wr),
        .res   (res)
    );

    assign res_valid   = out_valid_reg;
    assign accepted    = out_res_reg.accepted;
    assign list_count  = out_res_reg.list_count;
    assign owner_valid = out_res_reg.owner_valid;
    assign owner_list  = out_res_reg.owner_list;

endmodule

`default_nettype wire

FILE: rtl/dllm_checker.sv
// Port level checker for the linked list manager and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dllm_checker
    import dllm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic              accepted,
    input wire logic [CNT_W-1:0]  list_count,
    input wire logic              owner_valid,
    input wire logic [LIST_W-1:0] owner_list
);

    // A stalled result keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(accepted) && $stable(list_count)
            && $stable(owner_valid) && $stable(owner_list))
        else $error("result changed while stalled");

    // A rejected request reports an empty count.
    a_reject_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !accepted |-> list_count == '0)
        else $error("rejected request with nonzero count");

    // A free node reports list zero.
    a_free_owner: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !owner_valid |-> owner_list == '0)
        else $error("free node with nonzero owner");

    // An accepted request that leaves the node owned sees a nonempty list.
    a_owned_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && accepted && owner_valid |-> list_count != '0)
        else $error("owned node in an empty list");

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .accepted    (accepted),
    .list_count  (list_count),
    .owner_valid (owner_valid),
    .owner_list  (owner_list)
);

`default_nettype wire

FILE: test/tb_doubly_linked_list_manager.sv
// Self-checking testbench for the doubly linked list manager with a scoreboard of list outcomes.
`timescale 1ns / 1ps

module tb_doubly_linked_list_manager
    import dllm_pkg::*;
;

    localparam logic [NODE_W:0] NO_NODE      = (NODE_W+1)'(NODE_COUNT);
    localparam int              RANDOM_ITEMS = 1800;
    localparam int              PHASE_LEN    = 120;
    localparam int              HOLD_CYCLES  = 60;
    localparam int              CYCLE_LIMIT  = 200000;

    class list_pool_scoreboard;
        bit                  owned[NODE_COUNT];
        bit [LIST_W-1:0]     owner_of[NODE_COUNT];
        bit [NODE_W:0]       next_of[NODE_COUNT];
        bit [NODE_W:0]       prev_of[NODE_COUNT];
        bit [NODE_W:0]       head_of[LIST_COUNT];
        bit [NODE_W:0]       tail_of[LIST_COUNT];
        bit [CNT_W-1:0]      count_of[LIST_COUNT];
        res_t                awaited_outcomes[$];
        int                  mismatches;
        int                  results_seen;

        function new();
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                owned[i]    = 1'b0;
                owner_of[i] = '0;
                next_of[i]  = '0;
                prev_of[i]  = '0;
            end
            for (int i = 0; i < LIST_COUNT; i++)
            begin
                head_of[i]  = NO_NODE;
                tail_of[i]  = NO_NODE;
                count_of[i] = '0;
            end
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction

        function void link_node(bit [NODE_W-1:0] n, bit [LIST_W-1:0] l, bit at_tail);
            if (head_of[l] >= NO_NODE || tail_of[l] >= NO_NODE)
            begin
                next_of[n] = NO_NODE;
                prev_of[n] = NO_NODE;
                head_of[l] = {1'b0, n};
                tail_of[l] = {1'b0, n};
            end
            else if (at_tail)
            begin
                next_of[n] = NO_NODE;
                prev_of[n] = tail_of[l];
                next_of[tail_of[l][NODE_W-1:0]] = {1'b0, n};
                tail_of[l] = {1'b0, n};
            end
            else
            begin
                prev_of[n] = NO_NODE;
                next_of[n] = head_of[l];
                prev_of[head_of[l][NODE_W-1:0]] = {1'b0, n};
                head_of[l] = {1'b0, n};
            end
            owned[n]    = 1'b1;
            owner_of[n] = l;
            count_of[l] = count_of[l] + 1'b1;
        endfunction

        function void unlink_node(bit [NODE_W-1:0] n);
            bit [NODE_W:0]   p;
            bit [NODE_W:0]   x;
            bit [LIST_W-1:0] l;
            bit              has_prev;
            bit              has_next;
            p        = prev_of[n];
            x        = next_of[n];
            l        = owner_of[n];
            has_prev = p < NO_NODE;
            has_next = x < NO_NODE;
            if (has_next)
                prev_of[x[NODE_W-1:0]] = has_prev ? p : NO_NODE;
            else
                tail_of[l] = has_prev ? p : NO_NODE;
            if (has_prev)
                next_of[p[NODE_W-1:0]] = has_next ? x : NO_NODE;
            else
                head_of[l] = has_next ? x : NO_NODE;
            owned[n]   = 1'b0;
            next_of[n] = NO_NODE;
            prev_of[n] = NO_NODE;
            if (count_of[l] != 0)
                count_of[l] = count_of[l] - 1'b1;
        endfunction

        function res_t predict_outcome(cmd_t op, bit [LIST_W-1:0] l, bit [NODE_W-1:0] n);
            res_t            r;
            bit [LIST_W-1:0] former;
            r = '0;
            case (op)
                CMD_APPEND, CMD_PUSH:
                begin
                    if (!owned[n])
                    begin
                        link_node(n, l, op == CMD_APPEND);
                        r.accepted   = 1'b1;
                        r.list_count = count_of[l];
                    end
                end
                CMD_REMOVE:
                begin
                    if (owned[n])
                    begin
                        former = owner_of[n];
                        unlink_node(n);
                        r.accepted   = 1'b1;
                        r.list_count = count_of[former];
                    end
                end
                default:
                begin
                    r.accepted = 1'b1;
                    if (owned[n])
                        r.list_count = count_of[owner_of[n]];
                end
            endcase
            r.owner_valid = owned[n];
            r.owner_list  = owned[n] ? owner_of[n] : '0;
            return r;
        endfunction

        function void note_request(cmd_t op, bit [LIST_W-1:0] l, bit [NODE_W-1:0] n);
            awaited_outcomes.push_back(predict_outcome(op, l, n));
        endfunction

        task report(string msg);
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
            mismatches++;
        endtask

        task check_result(logic acc, logic [CNT_W-1:0] cnt, logic ov, logic [LIST_W-1:0] ol);
            res_t want;
            results_seen++;
            if (awaited_outcomes.size() == 0)
            begin
                report("result arrived with no request outstanding");
                return;
            end
            want = awaited_outcomes.pop_front();
            if (acc !== want.accepted)
                report($sformatf("accepted got %b expected %b", acc, want.accepted));
            if (cnt !== want.list_count)
                report($sformatf("list_count got %0d expected %0d", cnt, want.list_count));
            if (ov !== want.owner_valid)
                report($sformatf("owner_valid got %b expected %b", ov, want.owner_valid));
            if (ol !== want.owner_list)
                report($sformatf("owner_list got %0d expected %0d", ol, want.owner_list));
        endtask

        function bit [NODE_W-1:0] pick_node(bit want_owned);
            int unsigned pool[$];
            for (int i = 0; i < NODE_COUNT; i++)
                if (owned[i] == want_owned)
                    pool.push_back(i);
            if (pool.size() == 0 || $urandom_range(99) >= 85)
                return NODE_W'($urandom_range(NODE_COUNT - 1));
            return NODE_W'(pool[$urandom_range(pool.size() - 1)]);
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    logic [1:0]        command;
    logic [LIST_W-1:0] list_id;
    logic [NODE_W-1:0] node_id;
    logic              res_valid;
    logic              res_ready;
    logic              accepted;
    logic [CNT_W-1:0]  list_count;
    logic              owner_valid;
    logic [LIST_W-1:0] owner_list;

    list_pool_scoreboard sb;
    bit                  calm;
    bit                  stall_request;
    bit                  stall_done;
    int unsigned         cycle_count;

    doubly_linked_list_manager DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .list_id     (list_id),
        .node_id     (node_id),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .accepted    (accepted),
        .list_count  (list_count),
        .owner_valid (owner_valid),
        .owner_list  (owner_list)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[doubly_linked_list_manager] ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls at random, except during the calm stretch, and
    // holds off completely once when the sender asks for it.
    initial
    begin
        res_ready  = 1'b0;
        stall_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_done)
            begin
                res_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                stall_done = 1'b1;
                res_ready <= 1'b1;
            end
            else
                res_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && res_ready)
            sb.check_result(accepted, list_count, owner_valid, owner_list);

    task automatic send(input cmd_t op, input logic [LIST_W-1:0] lst,
                        input logic [NODE_W-1:0] nd);
        cmd_valid <= 1'b1;
        command   <= op;
        list_id   <= lst;
        node_id   <= nd;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_request(op, lst, nd);
    endtask

    task automatic rest(input int cycles, input bit until_drained);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
        if (until_drained)
            do @(posedge clk); while (sb.pending() != 0);
    endtask

    initial
    begin
        int              phase;
        int unsigned     pick;
        logic [LIST_W-1:0] focus;
        cmd_t            op;
        logic [LIST_W-1:0] lst;
        logic [NODE_W-1:0] nd;

        sb            = new();
        calm          = 1'b0;
        stall_request = 1'b0;
        cmd_valid     = 1'b0;
        command       = CMD_APPEND;
        list_id       = '0;
        node_id       = '0;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: free and owned nodes, every unlink position, rejections.
        send(CMD_QUERY,  3'd0, 6'd0);
        send(CMD_REMOVE, 3'd0, 6'd63);
        send(CMD_APPEND, 3'd0, 6'd0);
        send(CMD_APPEND, 3'd7, 6'd63);
        send(CMD_PUSH,   3'd0, 6'd42);
        send(CMD_APPEND, 3'd0, 6'd21);
        send(CMD_APPEND, 3'd5, 6'd0);
        send(CMD_PUSH,   3'd0, 6'd63);
        send(CMD_QUERY,  3'd2, 6'd21);
        send(CMD_REMOVE, 3'd0, 6'd0);
        send(CMD_REMOVE, 3'd0, 6'd42);
        send(CMD_PUSH,   3'd0, 6'd7);
        send(CMD_REMOVE, 3'd4, 6'd21);
        send(CMD_REMOVE, 3'd0, 6'd7);
        send(CMD_REMOVE, 3'd7, 6'd63);
        send(CMD_QUERY,  3'd7, 6'd63);
        send(CMD_APPEND, 3'd3, 6'd7);
        send(CMD_PUSH,   3'd6, 6'd1);
        send(CMD_PUSH,   3'd6, 6'd2);
        send(CMD_PUSH,   3'd6, 6'd3);
        send(CMD_REMOVE, 3'd1, 6'd2);
        send(CMD_REMOVE, 3'd6, 6'd3);
        send(CMD_REMOVE, 3'd6, 6'd3);
        send(CMD_QUERY,  3'd6, 6'd1);

        // Random requests in phases that fill one list, mix all lists, or drain them.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                phase = (i / PHASE_LEN) % 3;
                focus = LIST_W'($urandom_range(LIST_COUNT - 1));
            end
            calm = (i >= 600 && i < 900);
            if (i == 300)
                stall_request = 1'b1;
            if (i == 1000)
                rest(0, 1'b1);
            pick = $urandom_range(99);
            lst  = (phase == 0) ? focus : LIST_W'($urandom_range(LIST_COUNT - 1));
            if ((phase == 0 && pick < 85) || (phase == 1 && pick < 40) ||
                (phase == 2 && pick < 15))
            begin
                op = $urandom_range(1) ? CMD_APPEND : CMD_PUSH;
                nd = sb.pick_node(1'b0);
            end
            else if ((phase == 0 && pick < 95) || (phase == 1 && pick < 80) ||
                     (phase == 2 && pick < 90))
            begin
                op = CMD_REMOVE;
                nd = sb.pick_node(1'b1);
            end
            else
            begin
                op = CMD_QUERY;
                nd = NODE_W'($urandom_range(NODE_COUNT - 1));
            end
            send(op, lst, nd);
            if (!calm && $urandom_range(99) < 4)
                rest($urandom_range(4, 1), 1'b0);
        end
        calm = 1'b0;

        rest(0, 1'b1);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[doubly_linked_list_manager] OK");
        else
            $display("[doubly_linked_list_manager] ERROR");
        $finish;
    end

endmodule

FILE: doubly_linked_list_manager.f
rtl/dllm_pkg.sv
rtl/dllm_ram.sv
rtl/dllm_exec.sv
rtl/doubly_linked_list_manager.sv
rtl/dllm_checker.sv
test/tb_doubly_linked_list_manager.sv
